/* rtl/cafd_pkg.sv */
// Shared types and constants of the 1-D cell-averaging CFAR detector.
package cafd_pkg;

  // Fixed widths of the beat fields and configuration registers
  localparam int IN_SAMPLE_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int CNT_CFG_W   = 6;
  // Training cell count tl + tr fits here (at most 126)
  localparam int TRAIN_W     = CNT_CFG_W + 1;
  // Window geometry (sizes and positions up to 253)
  localparam int GEO_W       = CNT_CFG_W + 3;

  // Register indices
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAIN_LEFT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAIN_RIGHT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GUARD_LEFT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GUARD_RIGHT  = 3'd4;

  // Request types
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [IN_SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic detection;
    logic window_invalid;
  } out_item_t;

  // Control broadcast to every window cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic rotate;
  } cell_ctl_t;

endpackage

/* rtl/cafd_cell.sv */
// One window cell: holds a sample, loads from its neighbour on shift or rotate.
module cafd_cell import cafd_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctl_t              ctl,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] value
);

  // Clear wins, otherwise take the neighbour's value when the chain moves
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      value <= '0;
    end else if (ctl.shift || ctl.rotate) begin
      value <= din;
    end
  end

endmodule

/* rtl/cafd_div.sv */
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
module cafd_div #(
  parameter int DVD_W = 39,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = (dvs == '0) ? '0 : quo;

endmodule

/* rtl/ca_cfar_1d_detector.sv */
// Top level of the 1-D cell-averaging CFAR detector.
//
// Input channel in_valid/in_stall/in_data: a beat is a new sample or a restart.
// A restart clears the window, the fill count and the held flag and returns
// no result. Every sample returns one beat on out_valid/out_stall/out_data.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write
// only while the block is idle.
// While the window fills, or when the configured window exceeds WINDOW_DEPTH,
// a sample skips the scan and returns the held flag. For a full window the
// cell chain rotates once to sum the training cells and pick the cell under
// test, then the serial divider works out its SAMPLE_BITS + 7 quotient bits
// one at a time, then the threshold multiply and compare. One sample is in
// work at a time.
// The result sits in an output register; in_stall drops as soon as it is
// loaded, so the next beat is taken while a stalled result waits. A result
// that finds the output register still occupied waits until it drains.
// Reset (rst, synchronous) clears the window, counters, flag, configuration
// registers and the output valid flag.
module ca_cfar_1d_detector import cafd_pkg::*; #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = SAMPLE_BITS + TRAIN_W;
  localparam int THR_W = SUM_W + CFG_DATA_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_DATA_W-1:0] scale_factor;
  logic [CNT_CFG_W-1:0]  train_left;
  logic [CNT_CFG_W-1:0]  train_right;
  logic [CNT_CFG_W-1:0]  guard_left;
  logic [CNT_CFG_W-1:0]  guard_right;

  // Stream state and working registers
  logic [IDX_W-1:0]       fill_count;
  logic                   held;
  logic                   inv_flag;
  logic [IDX_W-1:0]       idx;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] cut_val;
  logic [THR_W-1:0]       thr;

  // Combinational helpers
  logic [GEO_W-1:0]       wsize;
  logic [GEO_W-1:0]       cut_pos;
  logic [GEO_W-1:0]       left_start;
  logic [GEO_W-1:0]       left_stop;
  logic [GEO_W-1:0]       pos;
  logic [TRAIN_W-1:0]     total;
  logic                   too_big;
  logic                   filling;
  logic                   is_train;
  logic [SUM_W-1:0]       sum_next;
  logic                   in_accept;
  logic                   out_free;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       quot;
  cell_ctl_t              cell_ctl;
  logic [SAMPLE_BITS-1:0] head_din;
  logic [SAMPLE_BITS-1:0] tail;
  logic [SAMPLE_BITS-1:0] cell_q [WINDOW_DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Window geometry from the configuration
  always_comb begin
    cut_pos    = GEO_W'(train_right) + GEO_W'(guard_right);
    left_start = cut_pos + GEO_W'(1) + GEO_W'(guard_left);
    left_stop  = left_start + GEO_W'(train_left);
    wsize      = left_stop;
    total      = {1'b0, train_left} + {1'b0, train_right};
    too_big    = wsize > GEO_W'(WINDOW_DEPTH);
    filling    = (GEO_W'(fill_count) + GEO_W'(1)) < wsize;
  end

  // Training cell test for the cell now at the chain tail
  always_comb begin
    pos      = GEO_W'(idx);
    is_train = (pos < GEO_W'(train_right)) || ((pos >= left_start) && (pos < left_stop));
    sum_next = sum + (is_train ? SUM_W'(tail) : SUM_W'(0));
  end

  // Chain control: shift on a sample, clear on a restart, rotate during the scan
  always_comb begin
    cell_ctl.clear  = in_accept && (in_data.req_type == REQ_RESTART);
    cell_ctl.shift  = in_accept && (in_data.req_type == REQ_SAMPLE);
    cell_ctl.rotate = (state == S_SCAN);
    head_din        = cell_ctl.shift ? in_data.sample_value[SAMPLE_BITS-1:0] : tail;
  end

  assign tail = cell_q[WINDOW_DEPTH-1];

  // Window cells, newest at position 0
  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    logic [SAMPLE_BITS-1:0] din;
    if (g == 0) begin : g_head
      assign din = head_din;
    end else begin : g_body
      assign din = cell_q[g-1];
    end
    cafd_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (cell_ctl),
      .din  (din),
      .value(cell_q[g])
    );
  end

  // Average of the training cells
  assign div_start = (state == S_SCAN) && (idx == '0);

  cafd_div #(
    .DVD_W(SUM_W),
    .DVS_W(TRAIN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_next),
    .divisor (total),
    .done    (div_done),
    .quotient(quot)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= '0;
      train_left   <= '0;
      train_right  <= '0;
      guard_left   <= '0;
      guard_right  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE_FACTOR: scale_factor <= cfg_data;
        REG_TRAIN_LEFT:   train_left   <= cfg_data[CNT_CFG_W-1:0];
        REG_TRAIN_RIGHT:  train_right  <= cfg_data[CNT_CFG_W-1:0];
        REG_GUARD_LEFT:   guard_left   <= cfg_data[CNT_CFG_W-1:0];
        REG_GUARD_RIGHT:  guard_right  <= cfg_data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      held       <= 1'b0;
      inv_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // result valid: set on load, cleared once the beat is taken
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (in_data.req_type == REQ_RESTART) begin
              fill_count <= '0;
              held       <= 1'b0;
            end else begin
              inv_flag <= too_big;
              if (too_big) begin
                state <= S_DONE;
              end else if (filling) begin
                fill_count <= fill_count + IDX_W'(1);
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (idx == '0) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          held  <= THR_W'(cut_val) > thr;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Scan datapath: index, running sum, cell under test, threshold
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      idx <= IDX_W'(WINDOW_DEPTH - 1);
      sum <= '0;
    end else if (state == S_SCAN) begin
      idx <= idx - IDX_W'(1);
      sum <= sum_next;
      if (pos == cut_pos) begin
        cut_val <= tail;
      end
    end
    if (state == S_MUL) begin
      thr <= THR_W'(quot) * THR_W'(scale_factor);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_data.detection      <= held;
      out_data.window_invalid <= inv_flag;
    end
  end

endmodule

/* rtl/cafd_checker.sv */
// Port-level checker for the CFAR detector, bound to the top level.
module cafd_checker import cafd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input in_item_t               in_data,
  input logic                   out_valid,
  input logic                   out_stall,
  input out_item_t              out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // An accepted sample leaves the input stalled on the following cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.req_type == REQ_SAMPLE) |=> in_stall)
    else $error("input not stalled after a sample beat");

  // A restart gives no result and leaves the block ready
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.req_type == REQ_RESTART)
    |=> !in_stall && !$rose(out_valid))
    else $error("restart produced a result or stalled the input");

  // A new result only appears at the end of a sample's work
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // Reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind ca_cfar_1d_detector cafd_checker u_cafd_checker (.*);

/* bench/cfar_detect_checker.sv */
// Beat monitor, detection predictor and result comparison for the CA-CFAR detector.
`timescale 1ns / 1ps

module cfar_detect_checker import cafd_pkg::*; #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     flags_pending
);

  localparam logic [63:0] KEEP_BITS = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam int          SHOWN_ERRS = 10;

  // Shadow copy of the configuration registers
  logic [7:0]           scale;
  logic [CNT_CFG_W-1:0] train_l, train_r, guard_l, guard_r;

  // Shadow copy of the stream state
  logic [IN_SAMPLE_W-1:0] cells [WINDOW_DEPTH];
  int unsigned            fill;
  logic                   held;

  out_item_t flags_due [$];
  int        errs = 0;

  function automatic void clear_stream();
    foreach (cells[i]) cells[i] = '0;
    fill = 0;
    held = 1'b0;
  endfunction

  // CA-CFAR decision on the current window contents
  function automatic logic cut_exceeds_threshold();
    int unsigned left_lo, left_hi, n_train;
    logic [63:0] total, mean, thresh, cut;
    total   = '0;
    left_lo = train_r + guard_r + 1 + guard_l;
    left_hi = left_lo + train_l;
    n_train = train_l + train_r;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (i < train_r || (i >= left_lo && i < left_hi)) total += cells[i];
    end
    // no training cells: mean is zero, any nonzero cut is a hit
    mean   = (n_train != 0) ? total / n_train : 64'd0;
    thresh = mean * scale;
    cut    = cells[(train_r + guard_r) % WINDOW_DEPTH];
    return cut > thresh;
  endfunction

  // Advance the shadow state by one accepted input beat
  function automatic void take_beat(in_item_t beat);
    int unsigned span;
    out_item_t   res;
    if (beat.req_type == REQ_RESTART) begin
      clear_stream();
      return;
    end
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) cells[i] = cells[i-1];
    cells[0] = beat.sample_value & KEEP_BITS[IN_SAMPLE_W-1:0];
    span = train_l + train_r + guard_l + guard_r + 1;
    // oversized window: no fill or flag update, held flag is repeated
    if (span <= WINDOW_DEPTH) begin
      if (fill + 1 < span) fill++;
      else held = cut_exceeds_threshold();
    end
    res.detection      = held;
    res.window_invalid = (span > WINDOW_DEPTH);
    flags_due.push_back(res);
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      scale   = '0;
      train_l = '0;
      train_r = '0;
      guard_l = '0;
      guard_r = '0;
      clear_stream();
      flags_due.delete();
    end else begin
      // compare an outgoing beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (flags_due.size() == 0) begin
          errs++;
          if (errs <= SHOWN_ERRS)
            $display("[%0t] unexpected result det=%0b inv=%0b", $realtime,
                     out_data.detection, out_data.window_invalid);
        end else begin
          want = flags_due.pop_front();
          if (out_data.detection !== want.detection ||
              out_data.window_invalid !== want.window_invalid) begin
            errs++;
            if (errs <= SHOWN_ERRS)
              $display("[%0t] result mismatch: exp det=%0b inv=%0b, got det=%0b inv=%0b",
                       $realtime, want.detection, want.window_invalid,
                       out_data.detection, out_data.window_invalid);
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE_FACTOR: scale   = cfg_data;
          REG_TRAIN_LEFT:   train_l = cfg_data[CNT_CFG_W-1:0];
          REG_TRAIN_RIGHT:  train_r = cfg_data[CNT_CFG_W-1:0];
          REG_GUARD_LEFT:   guard_l = cfg_data[CNT_CFG_W-1:0];
          REG_GUARD_RIGHT:  guard_r = cfg_data[CNT_CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_beat(in_data);
    end
    flags_pending <= flags_due.size();
    mismatches    <= errs;
  end

endmodule

/* bench/tb.sv */
// Stimulus, handshake pacing and verdict for the CA-CFAR detector bench.
`timescale 1ns / 1ps

module tb;
  import cafd_pkg::*;

  // index beyond the register file, writes to it are ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
  localparam int IDLE_PCT      = 12;
  localparam int SETTLE_CYCLES = 160;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 450;
  localparam int CALM_PHASE    = 3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatches;
  int flags_pending;
  bit calm       = 1'b0;
  int sent       = 0;
  int quiet      = 0;
  int stall_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  ca_cfar_1d_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfar_detect_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .flags_pending (flags_pending)
  );

  // Receiver back-pressure: occasional stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 3) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Cycles without any beat on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Leaves cfg_valid high so back-to-back writes follow without a gap
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_setting(logic [7:0] sc, logic [7:0] tl, logic [7:0] tr,
                              logic [7:0] gl, logic [7:0] gr);
    write_reg(REG_SCALE_FACTOR, sc);
    write_reg(REG_TRAIN_LEFT, tl);
    write_reg(REG_TRAIN_RIGHT, tr);
    write_reg(REG_GUARD_LEFT, gl);
    write_reg(REG_GUARD_RIGHT, gr);
    cfg_valid <= 1'b0;
  endtask

  // One input beat, with an occasional idle gap in front
  task automatic put_beat(logic req, logic [IN_SAMPLE_W-1:0] value);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {req, value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Sender holds off until every result is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (flags_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly low clutter with spikes, full-range values and extremes mixed in
  function automatic logic [IN_SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 200);
    if (roll < 85) return $urandom_range(1000, 100000);
    if (roll < 95) return $urandom;
    return ($urandom_range(0, 1) == 1) ? '1 : '0;
  endfunction

  task automatic run_phase();
    logic [7:0]  sc, tl, tr, gl, gr;
    int unsigned kind, room, beats;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) sc = 8'($urandom_range(0, 255));
    else sc = 8'($urandom_range(1, 6));
    if (kind == 0) begin
      // oversized window
      tl    = 8'($urandom_range(17, 63));
      tr    = 8'($urandom_range(17, 63));
      gl    = 8'($urandom_range(17, 63));
      gr    = 8'($urandom_range(17, 63));
      beats = $urandom_range(5, 12);
    end else if (kind <= 2) begin
      // window close to or exactly at the depth
      tl    = 8'($urandom_range(8, 31));
      tr    = 8'($urandom_range(8, 31));
      room  = 63 - tl - tr;
      gl    = 8'($urandom_range(0, room));
      gr    = 8'(($urandom_range(0, 1) == 1) ? room - gl : $urandom_range(0, room - gl));
      beats = $urandom_range(70, 100);
    end else begin
      tl    = 8'($urandom_range(0, 4));
      tr    = 8'($urandom_range(0, 4));
      gl    = 8'($urandom_range(0, 3));
      gr    = 8'($urandom_range(0, 3));
      beats = $urandom_range(15, 45);
    end
    // unused upper data bits of a count register
    if ($urandom_range(0, 4) == 0) tl[7:6] = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 4) == 0) gr[7:6] = 2'($urandom_range(1, 3));
    settle();
    load_setting(sc, tl, tr, gl, gr);
    if ($urandom_range(0, 1) == 1) put_beat(REQ_RESTART, $urandom);
    repeat (beats) begin
      if ($urandom_range(0, 39) == 0) put_beat(REQ_RESTART, $urandom);
      else put_beat(REQ_SAMPLE, pick_sample());
    end
  endtask

  initial begin : stimulus
    int phase_no;
    phase_no = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset setting: one-cell window, no training cells, zero scale
    load_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    put_beat(REQ_SAMPLE, 32'd0);
    put_beat(REQ_SAMPLE, 32'hFFFF_FFFF);
    put_beat(REQ_SAMPLE, 32'd1);
    put_beat(REQ_SAMPLE, 32'd0);

    // full-scale samples everywhere with the largest multiplier
    settle();
    load_setting(8'd255, 8'd2, 8'd2, 8'd1, 8'd1);
    repeat (7) put_beat(REQ_SAMPLE, 32'hFFFF_FFFF);

    // shrink the window mid-stream: the count is past the end, evaluates at once
    settle();
    load_setting(8'd1, 8'd1, 8'd1, 8'd0, 8'd0);
    put_beat(REQ_SAMPLE, 32'd4);
    put_beat(REQ_RESTART, 32'hA5A5_5A5A);
    put_beat(REQ_SAMPLE, 32'd4);
    put_beat(REQ_SAMPLE, 32'd9);
    put_beat(REQ_SAMPLE, 32'd4);
    put_beat(REQ_SAMPLE, 32'd4);

    // oversized window, counts written with their upper data bits set
    settle();
    write_reg(REG_SPARE, 8'hFF);
    load_setting(8'd7, 8'hFF, 8'd63, 8'h7F, 8'd63);
    put_beat(REQ_SAMPLE, 32'hFFFF_FFFF);
    put_beat(REQ_SAMPLE, 32'd0);
    put_beat(REQ_RESTART, 32'd0);
    put_beat(REQ_SAMPLE, 32'd123);

    // randomised phases, one of them with no idling on either side
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_no++;
      calm = (phase_no == CALM_PHASE);
      run_phase();
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0 && flags_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
